// File: design/mexp_pkg.sv
// Package for the modular exponentiation block.
// Holds the status type passed from the multiplier to the sequencer.
// No dependencies.
package mexp_pkg;

   typedef struct packed {
      logic busy;
      logic done;
   } mexp_status_type;

endpackage

// File: design/mexp_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing; WIDTH is set by the instantiating level.
interface mexp_req_chan #(parameter int WIDTH = 32);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] base_value;
   logic [WIDTH-1:0] exponent;
   logic [WIDTH-1:0] modulus;
   modport source (output valid, base_value, exponent, modulus, input ready);
   modport sink   (input valid, base_value, exponent, modulus, output ready);
endinterface

interface mexp_rsp_chan #(parameter int WIDTH = 32);
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] result_value;
   logic             error_flag;
   modport source (output valid, result_value, error_flag, input ready);
   modport sink   (input valid, result_value, error_flag, output ready);
endinterface

// File: design/mexp_cell.sv
// One bit cell of the multiplier operand chain.
// Loads a bit or takes its lower neighbor's bit each shift cycle.
module mexp_cell (
   input  logic clock,
   input  logic load,
   input  logic load_bit,
   input  logic shift,
   input  logic shift_in,
   output logic q
);
   logic bit_ff;
   logic bit_in;

   always_comb begin
      bit_in = bit_ff;
      if (load) begin
         bit_in = load_bit;
      end else if (shift) begin
         bit_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
   end

   assign q = bit_ff;
endmodule

// File: design/mexp_mulmod.sv
// Bit-serial modular multiplier with interleaved reduction.
// Uses mexp_cell for the operand chain and mexp_pkg for its status.
module mexp_mulmod #(
   parameter int WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [WIDTH-1:0]        op_a,
   input  logic [WIDTH-1:0]        op_b,
   input  logic [WIDTH-1:0]        op_m,
   output logic [WIDTH-1:0]        product,
   output mexp_pkg::mexp_status_type status
);
   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] a_ff, m_ff;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH-1:0] chain;
   logic [WIDTH:0]   dbl, sum;
   logic [WIDTH-1:0] r1, r2;

   genvar g;
   generate
      for (g = 0; g < WIDTH; g++) begin : g_cell
         mexp_cell u_cell (
            .clock    (clock),
            .load     (start),
            .load_bit (op_b[g]),
            .shift    (busy_ff),
            .shift_in ((g == 0) ? 1'b0 : chain[(g == 0) ? 0 : g - 1]),
            .q        (chain[g])
         );
      end
   endgenerate

   always_comb begin
      dbl = {acc_ff, 1'b0};
      r1  = (dbl >= {1'b0, m_ff}) ? WIDTH'(dbl - {1'b0, m_ff}) : dbl[WIDTH-1:0];
      sum = {1'b0, r1} + (chain[WIDTH-1] ? {1'b0, a_ff} : '0);
      r2  = (sum >= {1'b0, m_ff}) ? WIDTH'(sum - {1'b0, m_ff}) : sum[WIDTH-1:0];
   end

   always_comb begin
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         cnt_in  = CW'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = r2;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      if (start) begin
         a_ff <= op_a;
         m_ff <= op_m;
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign product     = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;
endmodule

// File: design/modular_exponentiation.sv
// Modular exponentiation, right-to-left square-and-multiply.
// Depends on mexp_pkg, mexp_if (channels) and mexp_mulmod.
//
// A request carries base_value, exponent and modulus; one response carries
// result_value and error_flag. Each modular product runs through a chain
// of WIDTH bit cells in the multiplier, one bit per cycle. An item takes one
// product to reduce the base, then per exponent bit up to its highest set
// bit one square and, for a set bit, one multiply.
// A zero modulus skips the multiplier and answers with error_flag set.
// One item is in work at a time; the next request is taken once the current
// result sits in the response register, so a stalled receiver holds at most
// one finished item while the next is computed.
// Reset is synchronous and clears the sequencer and the response valid.
module modular_exponentiation #(
   parameter int WIDTH = 32
) (
   input logic clock,
   input logic reset,
   mexp_req_chan.sink   req_chan,
   mexp_rsp_chan.source rsp_chan
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RED  = 3'd1;
   localparam logic [2:0] ST_NEXT = 3'd2;
   localparam logic [2:0] ST_MULR = 3'd3;
   localparam logic [2:0] ST_SQR  = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [WIDTH-1:0] b_ff, b_in, e_ff, e_in, m_ff, m_in, res_ff, res_in;
   logic             err_ff, err_in;
   logic             rv_ff, rv_in;
   logic [WIDTH-1:0] rres_ff;
   logic             rerr_ff;
   logic             start;
   logic [WIDTH-1:0] op_a, op_b;
   logic [WIDTH-1:0] product;
   logic             take, load_out;
   mexp_pkg::mexp_status_type mstat;

   mexp_mulmod #(.WIDTH(WIDTH)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .op_a    (op_a),
      .op_b    (op_b),
      .op_m    (m_in),
      .product (product),
      .status  (mstat)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign take     = req_chan.valid && req_chan.ready;
   assign load_out = (state_ff == ST_FIN) && (!rv_ff || rsp_chan.ready);

   always_comb begin
      state_in = state_ff;
      b_in     = b_ff;
      e_in     = e_ff;
      m_in     = m_ff;
      res_in   = res_ff;
      err_in   = err_ff;
      start    = 1'b0;
      op_a     = b_ff;
      op_b     = b_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               b_in   = req_chan.base_value;
               e_in   = req_chan.exponent;
               m_in   = req_chan.modulus;
               res_in = WIDTH'(1);
               err_in = (req_chan.modulus == '0);
               if (req_chan.modulus == '0) begin
                  res_in   = '0;
                  state_in = ST_FIN;
               end else begin
                  start    = 1'b1;
                  op_a     = WIDTH'(1);
                  op_b     = req_chan.base_value;
                  state_in = ST_RED;
               end
            end
         end
         ST_RED: begin
            if (mstat.done) begin
               b_in     = product;
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (e_ff == '0) begin
               state_in = ST_FIN;
            end else if (e_ff[0]) begin
               start    = 1'b1;
               op_a     = (res_ff >= m_ff) ? '0 : res_ff;
               op_b     = b_ff;
               state_in = ST_MULR;
            end else begin
               start    = 1'b1;
               state_in = ST_SQR;
            end
         end
         ST_MULR: begin
            if (mstat.done) begin
               res_in   = product;
               start    = 1'b1;
               state_in = ST_SQR;
            end
         end
         ST_SQR: begin
            if (mstat.done) begin
               b_in     = product;
               e_in     = e_ff >> 1;
               state_in = ST_NEXT;
            end
         end
         ST_FIN: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rv_in = rv_ff;
      if (load_out) begin
         rv_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      b_ff   <= b_in;
      e_ff   <= e_in;
      m_ff   <= m_in;
      res_ff <= res_in;
      err_ff <= err_in;
      if (load_out) begin
         rres_ff <= res_ff;
         rerr_ff <= err_ff;
      end
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
   end

   assign rsp_chan.valid        = rv_ff;
   assign rsp_chan.result_value = rres_ff;
   assign rsp_chan.error_flag   = rerr_ff;

   a_mul_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_FIN) |-> !mstat.busy)
      else $error("multiplier running outside an item");

   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      mstat.done |-> (state_ff == ST_RED || state_ff == ST_MULR || state_ff == ST_SQR))
      else $error("product finished with no state waiting");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      load_out && err_ff |=> rsp_chan.result_value == '0)
      else $error("error response with nonzero result");
endmodule
